@@ src/cda_pkg.sv @@
`default_nettype none

package cda_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD       = 2'd0,
        REQ_ADD_DAYS   = 2'd1,
        REQ_ADD_MONTHS = 2'd2,
        REQ_ADD_YEARS  = 2'd3
    } req_t;

    typedef enum logic {
        DIV_BY_12 = 1'b0,
        DIV_BY_25 = 1'b1
    } div_sel_t;

    localparam int DIVIDEND_W = 17;
    localparam int RECIP_W    = 18;
    localparam int PROD_W     = DIVIDEND_W + RECIP_W;
    localparam int QUOT_W     = 14;
    localparam int REM_W      = 5;
    localparam int RECIP_SHIFT = 21;

    // Reciprocals are ceil(2^21 / d). They are exact for 17-bit dividends by 12 and for
    // 16-bit dividends by 25.
    localparam logic [RECIP_W-1:0] RECIP_12 = 18'd174763;
    localparam logic [RECIP_W-1:0] RECIP_25 = 18'd83887;
    localparam logic [REM_W-1:0]   DIVISOR_12 = 5'd12;
    localparam logic [REM_W-1:0]   DIVISOR_25 = 5'd25;

    localparam logic [15:0] RESET_YEAR  = 16'd2000;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;
    localparam logic [3:0]  LAST_MONTH  = 4'd12;

    typedef struct packed {
        logic                  start;
        div_sel_t              sel;
        logic [DIVIDEND_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } div_rsp_t;

    // A year is a leap year when it divides by 4, unless it divides by 100 but not by 400.
    // With the remainder by 25 known, that reduces to checks on the low bits.
    function automatic logic leap_from(input logic [15:0] year, input logic [REM_W-1:0] rem25);
        leap_from = (year[1:0] == 2'd0) && ((rem25 != '0) || (year[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        if (month == 4'd2) begin
            month_len = leap ? 5'd29 : 5'd28;
        end else if (month < 4'd8) begin
            month_len = month[0] ? 5'd31 : 5'd30;
        end else begin
            month_len = month[0] ? 5'd30 : 5'd31;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/calendar_date_adder_unit.sv @@
// A load or an add of years waits on one division and an add of months on two; an add
// of days crosses one month boundary per step, plus one division per year boundary.
// One item is in work at a time; s_ready is high only while the sequencer is idle.
// Every leap year check goes through the shared reciprocal divider.
// Synchronous active-low reset sets the date to 2000-01-01 and empties the result register.
`default_nettype none

module calendar_date_adder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [15:0] s_amount,
    input  wire logic [15:0] s_load_year,
    input  wire logic [3:0]  s_load_month,
    input  wire logic [4:0]  s_load_day,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_cur_year,
    output logic [3:0]       m_cur_month,
    output logic [4:0]       m_cur_day,
    output logic             m_is_leap,
    output logic             m_accepted
);
    import cda_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WAIT,
        ST_MONTH_WAIT,
        ST_LEAP_WAIT,
        ST_DAYS,
        ST_CLAMP,
        ST_DONE
    } state_t;

    state_t      state_reg;
    req_t        req_reg;
    logic [15:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic        leap_reg;
    logic [15:0] amount_reg;
    logic [15:0] ld_year_reg;
    logic [3:0]  ld_month_reg;
    logic [4:0]  ld_day_reg;
    logic        ok_reg;
    logic        m_valid_reg;
    logic [15:0] m_year_reg;
    logic [3:0]  m_month_reg;
    logic [4:0]  m_day_reg;
    logic        m_leap_reg;
    logic        m_ok_reg;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    req_t        s_req;
    logic [15:0] year_inc;
    logic [15:0] year_plus_amt;
    logic [15:0] year_plus_quot;
    logic [4:0]  mlen_cur;
    logic [4:0]  left;
    logic        fits;
    logic        ld_leap;
    logic        load_ok;

    always_comb begin
        s_req          = req_t'(s_req_type);
        year_inc       = year_reg + 16'd1;
        year_plus_amt  = year_reg + s_amount;
        year_plus_quot = year_reg + {{(16-QUOT_W){1'b0}}, div_rsp.quot};
        mlen_cur       = month_len(month_reg, leap_reg);
        left           = mlen_cur - day_reg;
        fits           = amount_reg <= {11'd0, left};
        ld_leap        = leap_from(ld_year_reg, div_rsp.rem);
        load_ok        = (ld_month_reg != 4'd0) && (ld_month_reg <= LAST_MONTH)
                         && (ld_day_reg != 5'd0)
                         && (ld_day_reg <= month_len(ld_month_reg, ld_leap));
    end

    always_comb begin
        div_req = '{start: 1'b0, sel: DIV_BY_25, dividend: '0};
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_req)
                        REQ_LOAD: begin
                            div_req = '{start: 1'b1, sel: DIV_BY_25,
                                        dividend: {1'b0, s_load_year}};
                        end
                        REQ_ADD_MONTHS: begin
                            div_req = '{start: 1'b1, sel: DIV_BY_12,
                                        dividend: {13'd0, month_reg - 4'd1}
                                                  + {1'b0, s_amount}};
                        end
                        REQ_ADD_YEARS: begin
                            div_req = '{start: 1'b1, sel: DIV_BY_25,
                                        dividend: {1'b0, year_plus_amt}};
                        end
                        default: begin
                            div_req.start = 1'b0;
                        end
                    endcase
                end
            end
            ST_MONTH_WAIT: begin
                if (div_rsp.done) begin
                    div_req = '{start: 1'b1, sel: DIV_BY_25, dividend: {1'b0, year_plus_quot}};
                end
            end
            ST_DAYS: begin
                if (!fits && month_reg == LAST_MONTH) begin
                    div_req = '{start: 1'b1, sel: DIV_BY_25, dividend: {1'b0, year_inc}};
                end
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    cda_recip_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            year_reg    <= RESET_YEAR;
            month_reg   <= RESET_MONTH;
            day_reg     <= RESET_DAY;
            leap_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg      <= s_req;
                        amount_reg   <= s_amount;
                        ld_year_reg  <= s_load_year;
                        ld_month_reg <= s_load_month;
                        ld_day_reg   <= s_load_day;
                        ok_reg       <= 1'b1;
                        case (s_req)
                            REQ_LOAD:       state_reg <= ST_LOAD_WAIT;
                            REQ_ADD_DAYS:   state_reg <= ST_DAYS;
                            REQ_ADD_MONTHS: state_reg <= ST_MONTH_WAIT;
                            REQ_ADD_YEARS: begin
                                year_reg  <= year_plus_amt;
                                state_reg <= ST_LEAP_WAIT;
                            end
                            default:        state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_LOAD_WAIT: begin
                    if (div_rsp.done) begin
                        if (load_ok) begin
                            year_reg  <= ld_year_reg;
                            month_reg <= ld_month_reg;
                            day_reg   <= ld_day_reg;
                            leap_reg  <= ld_leap;
                        end else begin
                            ok_reg <= 1'b0;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_MONTH_WAIT: begin
                    if (div_rsp.done) begin
                        year_reg  <= year_plus_quot;
                        month_reg <= div_rsp.rem[3:0] + 4'd1;
                        state_reg <= ST_LEAP_WAIT;
                    end
                end
                ST_LEAP_WAIT: begin
                    if (div_rsp.done) begin
                        leap_reg  <= leap_from(year_reg, div_rsp.rem);
                        state_reg <= (req_reg == REQ_ADD_DAYS) ? ST_DAYS : ST_CLAMP;
                    end
                end
                ST_DAYS: begin
                    if (fits) begin
                        day_reg   <= day_reg + amount_reg[4:0];
                        state_reg <= ST_DONE;
                    end else begin
                        amount_reg <= amount_reg - {11'd0, left} - 16'd1;
                        day_reg    <= RESET_DAY;
                        if (month_reg == LAST_MONTH) begin
                            month_reg <= RESET_MONTH;
                            year_reg  <= year_inc;
                            state_reg <= ST_LEAP_WAIT;
                        end else begin
                            month_reg <= month_reg + 4'd1;
                        end
                    end
                end
                ST_CLAMP: begin
                    if (day_reg > mlen_cur) begin
                        day_reg <= mlen_cur;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_year_reg  <= year_reg;
                        m_month_reg <= month_reg;
                        m_day_reg   <= day_reg;
                        m_leap_reg  <= leap_reg;
                        m_ok_reg    <= ok_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_cur_year  = m_year_reg;
    assign m_cur_month = m_month_reg;
    assign m_cur_day   = m_day_reg;
    assign m_is_leap   = m_leap_reg;
    assign m_accepted  = m_ok_reg;

endmodule

`default_nettype wire

@@ src/cda_recip_div.sv @@
`default_nettype none

module cda_recip_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cda_pkg::div_req_t req,
    output cda_pkg::div_rsp_t     rsp
);
    import cda_pkg::*;

    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [DIVIDEND_W-1:0] dvd_reg;
    div_sel_t              sel_reg;
    logic                  stage_reg;
    logic                  done_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [QUOT_W-1:0]     quot_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [RECIP_W-1:0]    recip;
    logic [REM_W-1:0]      divisor;
    logic [QUOT_W+REM_W-1:0] back_prod;
    logic [QUOT_W+REM_W-1:0] diff;

    always_comb begin
        recip     = (req.sel == DIV_BY_25) ? RECIP_25 : RECIP_12;
        prod_next = {{RECIP_W{1'b0}}, req.dividend} * {{DIVIDEND_W{1'b0}}, recip};
        divisor   = (sel_reg == DIV_BY_25) ? DIVISOR_25 : DIVISOR_12;
        quot_next = prod_reg[RECIP_SHIFT +: QUOT_W];
        back_prod = {{REM_W{1'b0}}, quot_next} * {{QUOT_W{1'b0}}, divisor};
        diff      = {{(QUOT_W+REM_W-DIVIDEND_W){1'b0}}, dvd_reg} - back_prod;
        rem_next  = diff[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= req.start;
            done_reg  <= stage_reg;
            if (req.start) begin
                prod_reg <= prod_next;
                dvd_reg  <= req.dividend;
                sel_reg  <= req.sel;
            end
            if (stage_reg) begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
            end
        end
    end

    assign rsp = '{done: done_reg, quot: quot_reg, rem: rem_reg};

endmodule

`default_nettype wire

@@ src/cda_checker.sv @@
`default_nettype none

module cda_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_cur_year,
    input wire logic [3:0]  m_cur_month,
    input wire logic [4:0]  m_cur_day,
    input wire logic        m_is_leap,
    input wire logic        m_accepted
);

    // A result that waits must hold still.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cur_year) && $stable(m_cur_month)
                                && $stable(m_cur_day) && $stable(m_is_leap)
                                && $stable(m_accepted))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cur_month >= 4'd1 && m_cur_month <= 4'd12)
        else $error("month out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cur_day != 5'd0)
        else $error("day is zero");

    // The leap flag must agree with the year on its low bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cur_year[1:0] != 2'd0 |-> !m_is_leap)
        else $error("leap flag set on a year not divisible by 4");

endmodule

bind calendar_date_adder_unit cda_checker u_cda_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_cur_year  (m_cur_year),
    .m_cur_month (m_cur_month),
    .m_cur_day   (m_cur_day),
    .m_is_leap   (m_is_leap),
    .m_accepted  (m_accepted)
);

`default_nettype wire
